@@ hdl/mcd_pkg.sv @@
package mcd_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int SCALE_W     = 20;
  localparam int FRAC_SHIFT  = 26;
  localparam int PROD_W      = SAMPLE_W + SCALE_W + 1;
  localparam int QUOT_W      = PROD_W - FRAC_SHIFT;
  localparam int OUT_W       = 16;
  localparam int ZOOM_W      = 15;
  localparam int MAX_ZOOM    = 16384;
  localparam int CNT_W       = 17;
  localparam int COLS_W      = 9;
  localparam int MAX_COLUMNS = 256;
  localparam int IDX_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  localparam logic signed [SAMPLE_W-1:0] START_MAX = -24'sd5242880;
  localparam logic signed [SAMPLE_W-1:0] START_MIN = 24'sd5242880;

  localparam logic [ZOOM_W-1:0]  ZOOM_RST  = 15'd1;
  localparam logic [COLS_W-1:0]  COLS_RST  = 9'd128;
  localparam logic [SCALE_W-1:0] SCALE_RST = 20'd8192;

  localparam logic signed [QUOT_W-1:0] OUT_HI = 19'sd32767;
  localparam logic signed [QUOT_W-1:0] OUT_LO = -19'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZOOM   = 3'd0,
    REG_COLS   = 3'd1,
    REG_SCALE  = 3'd2,
    REG_STEREO = 3'd3,
    REG_CHSEL  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  group;
    logic [COLS_W-1:0] cols;
    logic              stereo;
    logic              chsel;
  } acc_cfg_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] min;
    logic signed [SAMPLE_W-1:0] max;
    logic [IDX_W-1:0]           idx;
  } pend_t;

  // product / 2^26, truncated toward zero, saturated to 16 bits
  function automatic logic signed [OUT_W-1:0] scale_sat(
    input logic signed [SAMPLE_W-1:0] s,
    input logic [SCALE_W-1:0]         k
  );
    logic signed [PROD_W-1:0] p;
    logic signed [QUOT_W-1:0] q;
    p = PROD_W'(s) * $signed({1'b0, k});
    q = p[PROD_W-1:FRAC_SHIFT];
    if (p[PROD_W-1] && (|p[FRAC_SHIFT-1:0])) begin
      q = q + QUOT_W'(1);
    end
    if (q > OUT_HI) begin
      return OUT_HI[OUT_W-1:0];
    end else if (q < OUT_LO) begin
      return OUT_LO[OUT_W-1:0];
    end
    return q[OUT_W-1:0];
  endfunction

endpackage

@@ hdl/mcd_if.sv @@
interface sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [mcd_pkg::SAMPLE_W-1:0] sample_first;
  logic signed [mcd_pkg::SAMPLE_W-1:0] sample_second;
  modport source (output valid, sample_first, sample_second, input ready);
  modport sink (input valid, sample_first, sample_second, output ready);
endinterface

interface column_if;
  logic                             valid;
  logic                             ready;
  logic signed [mcd_pkg::OUT_W-1:0] column_min;
  logic signed [mcd_pkg::OUT_W-1:0] column_max;
  logic [mcd_pkg::IDX_W-1:0]        column_index;
  modport source (output valid, column_min, column_max, column_index, input ready);
  modport sink (input valid, column_min, column_max, column_index, output ready);
endinterface

@@ hdl/mcd_accum.sv @@
module mcd_accum (
  input  logic                clk,
  input  logic                rst,
  input  mcd_pkg::acc_cfg_t   cfg,
  input  logic                accept,
  input  logic signed [mcd_pkg::SAMPLE_W-1:0] sample_first,
  input  logic signed [mcd_pkg::SAMPLE_W-1:0] sample_second,
  input  logic                advance,
  output mcd_pkg::pend_t      pend
);

  logic signed [mcd_pkg::SAMPLE_W-1:0] running_max, running_max_next;
  logic signed [mcd_pkg::SAMPLE_W-1:0] running_min, running_min_next;
  logic [mcd_pkg::CNT_W-1:0]           count, count_inc;
  logic [mcd_pkg::IDX_W-1:0]           column, column_next;
  logic [mcd_pkg::COLS_W-1:0]          column_inc;
  logic signed [mcd_pkg::SAMPLE_W-1:0] sel;
  logic                                done;

  always_comb begin
    sel = (cfg.stereo && cfg.chsel) ? sample_second : sample_first;
    running_max_next = (sel > running_max) ? sel : running_max;
    running_min_next = (sel < running_min) ? sel : running_min;
    count_inc = count + mcd_pkg::CNT_W'(1);
    done = (count_inc >= cfg.group);
    column_inc = {1'b0, column} + mcd_pkg::COLS_W'(1);
    column_next = (column_inc >= cfg.cols) ? '0 : column_inc[mcd_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= mcd_pkg::START_MAX;
      running_min <= mcd_pkg::START_MIN;
      count       <= '0;
      column      <= '0;
      pend.valid  <= 1'b0;
    end else begin
      pend.valid <= (accept && done) || (pend.valid && !advance);
      if (accept) begin
        if (done) begin
          running_max <= mcd_pkg::START_MAX;
          running_min <= mcd_pkg::START_MIN;
          count       <= '0;
          column      <= column_next;
        end else begin
          running_max <= running_max_next;
          running_min <= running_min_next;
          count       <= count_inc;
        end
      end
    end
    if (accept && done) begin
      pend.min <= running_min_next;
      pend.max <= running_max_next;
      pend.idx <= column;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> count == '0 && running_max == mcd_pkg::START_MAX)
    else $error("group did not restart");
  a_count: assert property (@(posedge clk) disable iff (rst)
    accept && !done |=> count == $past(count) + mcd_pkg::CNT_W'(1))
    else $error("sample count did not step");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pend.valid && !advance |=> pend.valid && $stable(pend.idx))
    else $error("pending column lost");
  a_order: assert property (@(posedge clk) disable iff (rst)
    pend.valid |-> pend.min <= pend.max)
    else $error("column min above max");

endmodule

@@ hdl/mcd_scale.sv @@
module mcd_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mcd_pkg::SCALE_W-1:0]   column_scale,
  input  mcd_pkg::pend_t                pend,
  output logic                          advance,
  column_if.source                      col
);

  logic open;

  assign open    = !col.valid || col.ready;
  assign advance = pend.valid && open;

  always_ff @(posedge clk) begin
    if (rst) begin
      col.valid <= 1'b0;
    end else if (open) begin
      col.valid <= pend.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      col.column_min   <= mcd_pkg::scale_sat(pend.min, column_scale);
      col.column_max   <= mcd_pkg::scale_sat(pend.max, column_scale);
      col.column_index <= pend.idx;
    end
  end

  a_load: assert property (@(posedge clk) disable iff (rst)
    advance |=> col.valid)
    else $error("column transaction not loaded");
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    col.valid |-> col.column_min <= col.column_max)
    else $error("scaled min above max");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    advance |=> col.column_index == $past(pend.idx))
    else $error("column index mismatch");

endmodule

@@ hdl/minmax_column_decimator_unit.sv @@
// channel  dir  payload                                   handshake
// smp      in   sample_first, sample_second               valid/ready
// col      out  column_min, column_max, column_index      valid/ready
// cfg      in   cfg_index, cfg_data                       cfg_we only
//
// One sample transaction per cycle while smp.ready is high, no bubbles between groups.
// The sample that closes a group is registered as a pending column in the
// min/max tracker, then scaled into the multiply/saturate output register.
// Output stalls back up through one pending column; smp.ready drops only
// when both the pending slot and the output register are full.
// Synchronous reset restores the register defaults and an empty group.
module minmax_column_decimator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcd_pkg::CFG_DATA_W-1:0]   cfg_data,
  sample_if.sink                           smp,
  column_if.source                         col
);

  logic [mcd_pkg::ZOOM_W-1:0]  zoom_level;
  logic [mcd_pkg::COLS_W-1:0]  column_count;
  logic [mcd_pkg::SCALE_W-1:0] column_scale;
  logic                        stereo_mode;
  logic                        channel_select;
  logic [mcd_pkg::ZOOM_W-1:0]  zoom_eff;
  mcd_pkg::acc_cfg_t           acfg;
  mcd_pkg::pend_t              pend;
  logic                        advance;
  logic                        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom_level     <= mcd_pkg::ZOOM_RST;
      column_count   <= mcd_pkg::COLS_RST;
      column_scale   <= mcd_pkg::SCALE_RST;
      stereo_mode    <= 1'b0;
      channel_select <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcd_pkg::REG_ZOOM:   zoom_level     <= cfg_data[mcd_pkg::ZOOM_W-1:0];
        mcd_pkg::REG_COLS:   column_count   <= cfg_data[mcd_pkg::COLS_W-1:0];
        mcd_pkg::REG_SCALE:  column_scale   <= cfg_data;
        mcd_pkg::REG_STEREO: stereo_mode    <= cfg_data[0];
        mcd_pkg::REG_CHSEL:  channel_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (zoom_level == '0) begin
      zoom_eff = mcd_pkg::ZOOM_W'(1);
    end else if (zoom_level > mcd_pkg::ZOOM_W'(mcd_pkg::MAX_ZOOM)) begin
      zoom_eff = mcd_pkg::ZOOM_W'(mcd_pkg::MAX_ZOOM);
    end else begin
      zoom_eff = zoom_level;
    end
    acfg.group = {zoom_eff, 2'b00};
    if (column_count == '0) begin
      acfg.cols = mcd_pkg::COLS_W'(1);
    end else if (column_count > mcd_pkg::COLS_W'(mcd_pkg::MAX_COLUMNS)) begin
      acfg.cols = mcd_pkg::COLS_W'(mcd_pkg::MAX_COLUMNS);
    end else begin
      acfg.cols = column_count;
    end
    acfg.stereo = stereo_mode;
    acfg.chsel  = channel_select;
  end

  assign smp.ready = !pend.valid || advance;
  assign accept    = smp.valid && smp.ready;

  mcd_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .cfg           (acfg),
    .accept        (accept),
    .sample_first  (smp.sample_first),
    .sample_second (smp.sample_second),
    .advance       (advance),
    .pend          (pend)
  );

  mcd_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .column_scale (column_scale),
    .pend         (pend),
    .advance      (advance),
    .col          (col)
  );

endmodule
